### design/page_framebuffer_glyph_blitter_core_assert.svh
// Assertion macros shared by the framebuffer glyph blitter files.
`ifndef PAGE_FRAMEBUFFER_GLYPH_BLITTER_CORE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_GLYPH_BLITTER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PFGB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication with the consequent checked in the cycle after the antecedent.
`define PFGB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### design/pfgb_pkg.sv
// Package with types and constants of the framebuffer glyph blitter.
package pfgb_pkg;
    localparam int ScreenWidth = 128;
    localparam int ScreenHeight = 64;
    localparam int PageCount = (ScreenHeight + 7) / 8;
    localparam int StoreBytes = PageCount * ScreenWidth;
    localparam int AddrW = $clog2(StoreBytes);

    localparam logic [2:0] CMD_SET = 3'd0;
    localparam logic [2:0] CMD_CLR = 3'd1;
    localparam logic [2:0] CMD_RECT = 3'd2;
    localparam logic [2:0] CMD_GLYPH = 3'd3;
    localparam logic [2:0] CMD_BYTE = 3'd4;
    localparam logic [2:0] CMD_READ = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0] size_w;
        logic [7:0] size_h;
        logic [6:0] glyph_x_offset;
        logic signed [7:0] glyph_y_offset;
        logic [7:0] glyph_advance;
        logic ink;
        logic [7:0] bitmap_byte;
        logic [9:0] read_index;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [9:0] read_echo;
    } rsp_t;

    // One pixel write request from the sequencer to the framebuffer.
    typedef struct packed {
        logic valid;
        logic signed [19:0] col;
        logic signed [19:0] row;
        logic on;
    } pix_t;
endpackage

### design/pfgb_stream_if.sv
// Valid/ready channel carrying one payload.
interface pfgb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/pfgb_fb.sv
// Framebuffer memory with a read-modify-write pixel pipeline and a read port.
module pfgb_fb (
    input logic clk,
    input logic rst_n,
    input pfgb_pkg::pix_t pix,
    input logic rd_req,
    input logic [9:0] rd_index,
    output logic clr_busy,
    output logic busy,
    output logic [7:0] rd_data
);
    import pfgb_pkg::*;
`include "page_framebuffer_glyph_blitter_core_assert.svh"

    logic [7:0] mem [StoreBytes];
    logic [AddrW:0] clr_reg;
    logic s1_valid_reg, s1_on_reg, rd_oob_reg;
    logic [AddrW-1:0] s1_addr_reg;
    logic [2:0] s1_bit_reg;
    logic [7:0] q_reg;
    logic in_screen;
    logic [AddrW-1:0] addr;
    logic [7:0] merged;

    assign clr_busy = !clr_reg[AddrW];
    assign busy = s1_valid_reg;
    assign in_screen = pix.col >= 0 && pix.col < ScreenWidth &&
                       pix.row >= 0 && pix.row < ScreenHeight;
    assign addr = AddrW'(((pix.row >>> 3) * ScreenWidth) + pix.col);

    always_comb
    begin
        merged = q_reg;
        merged[s1_bit_reg] = s1_on_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy)
                clr_reg <= clr_reg + 1'b1;
            s1_valid_reg <= pix.valid && in_screen;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= addr;
        s1_bit_reg <= pix.row[2:0];
        s1_on_reg <= pix.on;
        rd_oob_reg <= rd_index >= StoreBytes;
        if (clr_busy)
            mem[clr_reg[AddrW-1:0]] <= '0;
        else if (s1_valid_reg)
            mem[s1_addr_reg] <= merged;
        if (pix.valid)
            q_reg <= mem[addr];
        else if (rd_req)
            q_reg <= mem[rd_index[AddrW-1:0]];
    end

    assign rd_data = rd_oob_reg ? 8'd0 : q_reg;

    `PFGB_ASSERT_IMP(a_no_pix_clear, clk, rst_n, clr_busy, !pix.valid)
    `PFGB_ASSERT_IMP(a_no_overlap, clk, rst_n, s1_valid_reg, !pix.valid && !rd_req)
    `PFGB_ASSERT_IMP(a_one_op, clk, rst_n, pix.valid, !rd_req)
endmodule

### design/page_framebuffer_glyph_blitter_core.sv
// Top level of the page framebuffer glyph blitter.
// Usage: commands arrive on the req channel (pfgb_stream_if sink) and read
// results leave on the rsp channel (source). The framebuffer is a 128x64
// one-bit image in pages of eight rows, held in a 1024-byte memory.
// Each pixel is a read-modify-write: the memory byte is read, then the merged
// byte is written back; the sequencer waits for the write before the next read,
// so accesses to the same byte never overlap. A glyph start sweeps its margins
// as rectangles, and a bitmap byte walks its eight bits (fewer when the glyph
// ends inside it). A read result waits in the output register until taken.
// The pixel read-modify-write loop through the single memory port sets the
// rate of everything but reads.
// After reset the memory is cleared one byte per cycle, with no request accepted
// during that pass. Glyph state resets to zero, bar the bitmap byte and bit count.
// When the receiver stalls, a read result holds in the output register and
// no new request is taken until it is delivered.
module page_framebuffer_glyph_blitter_core (
    input logic clk,
    input logic rst_n,
    pfgb_stream_if.sink req,
    pfgb_stream_if.source rsp
);
    import pfgb_pkg::*;
`include "page_framebuffer_glyph_blitter_core_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RECT = 3'd1;   // sweeping a rectangle
    localparam logic [2:0] ST_BITS = 3'd2;   // walking bitmap bits
    localparam logic [2:0] ST_READ = 3'd3;   // memory read in flight
    localparam logic [2:0] ST_OUT = 3'd4;    // result waits for the receiver
    localparam logic [2:0] ST_WAIT = 3'd5;   // one pixel written, wait for memory

    logic [2:0] st_reg, st_next, ret_reg, ret_next;
    req_t r;
    // Rectangle sweep: origin, sizes and counters. A glyph start queues the
    // right margin as a second rectangle.
    logic signed [19:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [8:0] rw_reg, rw_next, rh_reg, rh_next, ci_reg, ci_next, ri_reg, ri_next;
    logic on_reg, on_next;
    logic pend_reg, pend_next;
    logic signed [19:0] px2_reg, px2_next;
    logic [8:0] pw2_reg, pw2_next;
    // Glyph state.
    logic signed [19:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [7:0] gw_reg, gw_next, gh_reg, gh_next, grow_reg, grow_next, gcol_reg, gcol_next;
    logic ginv_reg, ginv_next, gact_reg, gact_next;
    logic [7:0] bb_reg, bb_next;
    logic [3:0] k_reg, k_next;
    logic [9:0] echo_reg, echo_next;
    pix_t pix;
    logic rd_req, clr_busy, fb_busy;
    logic [7:0] rd_data;
    logic signed [19:0] ty;
    logic signed [19:0] yo;
    logic signed [19:0] rend;

    pfgb_fb u_fb (
        .clk(clk), .rst_n(rst_n), .pix(pix), .rd_req(rd_req),
        .rd_index(echo_reg), .clr_busy(clr_busy), .busy(fb_busy), .rd_data(rd_data)
    );

    assign r = req.payload;
    assign req.ready = st_reg == ST_IDLE && !clr_busy;
    assign rsp.valid = st_reg == ST_OUT;
    assign rsp.payload = {rd_data, echo_reg};
    assign rd_req = st_reg == ST_READ && !fb_busy;
    assign ty = 20'(ScreenHeight) - (gy_reg + 20'(grow_reg));
    assign yo = 20'(r.pos_y) + 20'(r.glyph_y_offset);
    assign rend = 20'(r.glyph_advance) + 20'sd1 - 20'(r.size_w) - 20'(r.glyph_x_offset);

    always_comb
    begin
        st_next = st_reg; ret_next = ret_reg;
        rx_next = rx_reg; ry_next = ry_reg; rw_next = rw_reg; rh_next = rh_reg;
        ci_next = ci_reg; ri_next = ri_reg; on_next = on_reg;
        pend_next = pend_reg; px2_next = px2_reg; pw2_next = pw2_reg;
        gx_next = gx_reg; gy_next = gy_reg; gw_next = gw_reg; gh_next = gh_reg;
        grow_next = grow_reg; gcol_next = gcol_reg; ginv_next = ginv_reg;
        gact_next = gact_reg; bb_next = bb_reg; k_next = k_reg; echo_next = echo_reg;
        pix = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    case (r.cmd)
                        CMD_SET, CMD_CLR:
                        begin
                            pix.valid = 1'b1;
                            pix.col = 20'(r.pos_x);
                            pix.row = 20'(r.pos_y);
                            pix.on = r.cmd == CMD_SET;
                            ret_next = ST_IDLE;
                            st_next = ST_WAIT;
                        end
                        CMD_RECT:
                        begin
                            rx_next = 20'(r.pos_x); ry_next = 20'(r.pos_y);
                            rw_next = {1'b0, r.size_w}; rh_next = {1'b0, r.size_h};
                            ci_next = '0; ri_next = '0; on_next = r.ink;
                            pend_next = 1'b0;
                            st_next = ST_RECT;
                        end
                        CMD_GLYPH:
                        begin
                            rx_next = 20'(r.pos_x); ry_next = yo;
                            rw_next = {2'b0, r.glyph_x_offset}; rh_next = {1'b0, r.size_h};
                            ci_next = '0; ri_next = '0; on_next = r.ink;
                            pend_next = rend > 0;
                            px2_next = 20'(r.pos_x) + 20'(r.size_w) + 20'(r.glyph_x_offset);
                            pw2_next = rend[8:0];
                            gx_next = 20'(r.pos_x) + 20'(r.glyph_x_offset);
                            gy_next = yo;
                            gw_next = r.size_w; gh_next = r.size_h;
                            ginv_next = r.ink; grow_next = '0; gcol_next = '0;
                            gact_next = r.size_w != 0 && r.size_h != 0;
                            st_next = ST_RECT;
                        end
                        CMD_BYTE:
                        begin
                            if (gact_reg)
                            begin
                                bb_next = r.bitmap_byte;
                                k_next = '0;
                                st_next = ST_BITS;
                            end
                        end
                        CMD_READ:
                        begin
                            echo_next = r.read_index;
                            st_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RECT:
            begin
                if (rw_reg == 0 || rh_reg == 0 || ci_reg >= rw_reg)
                begin
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        rx_next = px2_reg; rw_next = pw2_reg;
                        ci_next = '0; ri_next = '0;
                    end
                    else
                        st_next = ST_IDLE;
                end
                else
                begin
                    pix.valid = 1'b1;
                    pix.col = rx_reg + 20'(ci_reg);
                    pix.row = 20'(ScreenHeight) - (ry_reg + 20'(ri_reg));
                    pix.on = on_reg;
                    if (ri_reg + 1'b1 >= rh_reg)
                    begin
                        ri_next = '0;
                        ci_next = ci_reg + 1'b1;
                    end
                    else
                        ri_next = ri_reg + 1'b1;
                    ret_next = ST_RECT;
                    st_next = ST_WAIT;
                end
            end
            ST_BITS:
            begin
                if (k_reg[3] || !gact_reg)
                    st_next = ST_IDLE;
                else if (gcol_reg == 0 && (ty < 0 || ty >= ScreenHeight))
                begin
                    gact_next = 1'b0;
                    st_next = ST_IDLE;
                end
                else
                begin
                    pix.valid = 1'b1;
                    pix.col = gx_reg + 20'(gcol_reg);
                    pix.row = ty;
                    pix.on = bb_reg[7] ^ ginv_reg;
                    bb_next = {bb_reg[6:0], 1'b0};
                    k_next = k_reg + 1'b1;
                    if (gcol_reg + 1'b1 >= gw_reg)
                    begin
                        gcol_next = '0;
                        grow_next = grow_reg + 1'b1;
                        if (grow_reg + 1'b1 >= gh_reg)
                            gact_next = 1'b0;
                    end
                    else
                        gcol_next = gcol_reg + 1'b1;
                    ret_next = ST_BITS;
                    st_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                st_next = ret_reg;
            end
            ST_READ:
            begin
                if (rd_req)
                    st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                    st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; ret_reg <= ST_IDLE;
            gx_reg <= '0; gy_reg <= '0; gw_reg <= '0; gh_reg <= '0;
            grow_reg <= '0; gcol_reg <= '0; ginv_reg <= 1'b0; gact_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; ret_reg <= ret_next;
            gx_reg <= gx_next; gy_reg <= gy_next; gw_reg <= gw_next; gh_reg <= gh_next;
            grow_reg <= grow_next; gcol_reg <= gcol_next; ginv_reg <= ginv_next;
            gact_reg <= gact_next; pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= rx_next; ry_reg <= ry_next; rw_reg <= rw_next; rh_reg <= rh_next;
        ci_reg <= ci_next; ri_reg <= ri_next; on_reg <= on_next;
        px2_reg <= px2_next; pw2_reg <= pw2_next;
        bb_reg <= bb_next; k_reg <= k_next; echo_reg <= echo_next;
    end

    `PFGB_ASSERT_IMP(a_rsp_only_out, clk, rst_n, rsp.valid, st_reg == ST_OUT)
    `PFGB_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(echo_reg))
    `PFGB_ASSERT_NEXT(a_wait_after_pix, clk, rst_n, pix.valid, st_reg == ST_WAIT)
endmodule
